// File: hw/rtl/hbw_pkg.sv
`default_nettype none
package hbw_pkg;

  localparam int MAX_RESETS_DEF = 16;
  localparam int TIME_BITS_DEF  = 40;

  localparam int THR_W   = 22;
  localparam int MISS_W  = 8;
  localparam int STORM_W = 5;
  localparam int WIN_W   = 22;
  localparam int CFG_W   = 22;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W   = 16;

  localparam logic [THR_W-1:0]   STALE_RST  = THR_W'(2000);
  localparam logic [MISS_W-1:0]  LIMIT_RST  = MISS_W'(10);
  localparam logic [STORM_W-1:0] STORM_RST  = STORM_W'(10);
  localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(180000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALE_THR  = 2'd0,
    REG_MISS_LIMIT = 2'd1,
    REG_STORM_CNT  = 2'd2,
    REG_STORM_WIN  = 2'd3
  } hbw_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOG,
    ST_PRUNE,
    ST_DECIDE,
    ST_DONE
  } hbw_state_t;

  // Commands from the sequencer to the chain of reset-time cells.
  typedef struct packed {
    logic push;
    logic pop;
  } hbw_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/hbw_cell.sv
`default_nettype none
module hbw_cell #(
  parameter int TIME_BITS = hbw_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [TIME_BITS-1:0] wr_data,
  input  wire logic                 shift,
  input  wire logic [TIME_BITS-1:0] next_data,
  output logic      [TIME_BITS-1:0] data
);
  import hbw_pkg::*;

  logic [TIME_BITS-1:0] data_r;
  logic [TIME_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (wr_en) begin
      data_nxt = wr_data;
    end else if (shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

// File: hw/rtl/hbw_chain.sv
`default_nettype none
module hbw_chain #(
  parameter int MAX_RESETS = hbw_pkg::MAX_RESETS_DEF,
  parameter int TIME_BITS  = hbw_pkg::TIME_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_RESETS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hbw_pkg::hbw_ctl_t    ctl,
  input  wire logic [TIME_BITS-1:0] push_time,
  output logic      [TIME_BITS-1:0] head_time,
  output logic      [CNT_W-1:0]     count
);
  import hbw_pkg::*;

  logic [TIME_BITS-1:0] cell_data [MAX_RESETS];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 full;
  logic                 shift;

  // The oldest entry sits in cell 0. A pop, or a push into a full chain,
  // moves every entry one cell down.
  assign full  = (count_r == CNT_W'(MAX_RESETS));
  assign shift = ctl.pop || (ctl.push && full);

  for (genvar i = 0; i < MAX_RESETS; i++) begin : g_cell
    logic                 wr_en;
    logic [TIME_BITS-1:0] next_data;

    assign wr_en = ctl.push &&
                   (full ? (i == MAX_RESETS - 1) : (count_r == CNT_W'(i)));
    if (i == MAX_RESETS - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    hbw_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_data  (push_time),
      .shift    (shift),
      .next_data(next_data),
      .data     (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop && count_r != '0) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_time = cell_data[0];
  assign count     = count_r;

endmodule
`default_nettype wire

// File: hw/rtl/heartbeat_watchdog_storm_limit.sv
`default_nettype none
// Order of states: a skipped or non-limit tick passes through ST_CALC and then
// ST_DONE before out_tvalid rises; a tick that reaches the miss limit passes through
// ST_LOG, ST_PRUNE (P logged resets pruned from the window, at most MAX_RESETS - 1,
// one per cycle) and ST_DECIDE in between. One transaction at a time: a new tick is
// taken only once the last result is registered; a stalled result holds it back.
// Reset (rst_n, synchronous): counters, flags and the log count clear, and the
// configuration registers take their default values.
module heartbeat_watchdog_storm_limit #(
  parameter int MAX_RESETS = hbw_pkg::MAX_RESETS_DEF,
  parameter int TIME_BITS  = hbw_pkg::TIME_BITS_DEF,
  localparam int IN_W      = ((2 * TIME_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // now_ms, heartbeat_ms, worker_alive, reset_pending, zero fill
  input  wire logic [IN_W-1:0]             in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // request_reset, fatal_stop, misses[7:0], recent_resets[4:0], skipped
  output logic [hbw_pkg::OUT_W-1:0]        out_tdata,
  input  wire logic                        cfg_wr_en,
  input  wire logic [hbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hbw_pkg::CFG_W-1:0]   cfg_wdata
);
  import hbw_pkg::*;

  localparam int CNT_W = $clog2(MAX_RESETS + 1);
  localparam int CMP_W = (CNT_W > STORM_W) ? CNT_W : STORM_W;

  logic [THR_W-1:0]   stale_thr_r;
  logic [MISS_W-1:0]  miss_limit_r;
  logic [STORM_W-1:0] storm_cnt_r;
  logic [WIN_W-1:0]   storm_win_r;

  hbw_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] hb_r;
  logic                 alive_r;
  logic                 pend_r;
  logic                 skip_r;
  logic                 request_r;
  logic [MISS_W-1:0]    miss_r;
  logic [MISS_W-1:0]    miss_nxt;
  logic                 fatal_r;
  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  hbw_ctl_t             ctl;
  logic [TIME_BITS-1:0] head_time;
  logic [CNT_W-1:0]     count;

  logic skip;
  logic stale;
  logic expired;
  logic at_limit;
  logic storm;
  logic out_free;

  hbw_chain #(
    .MAX_RESETS(MAX_RESETS),
    .TIME_BITS (TIME_BITS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .push_time(now_r),
    .head_time(head_time),
    .count    (count)
  );

  // A time in the future is never older than the limit: compare now against
  // then + limit in one extra bit instead of forming a signed age.
  assign skip    = !alive_r || fatal_r || pend_r;
  assign stale   = {1'b0, now_r} > ({1'b0, hb_r} + (TIME_BITS+1)'(stale_thr_r));
  assign expired = (count != '0) &&
                   ({1'b0, now_r} > ({1'b0, head_time} + (TIME_BITS+1)'(storm_win_r)));
  assign storm   = CMP_W'(count) >= CMP_W'(storm_cnt_r);
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    if (stale) begin
      miss_nxt = (miss_r == '1) ? miss_r : miss_r + MISS_W'(1);
    end else begin
      miss_nxt = '0;
    end
  end
  assign at_limit = miss_nxt >= miss_limit_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_CALC;
      ST_CALC:   state_nxt = (!skip && at_limit) ? ST_LOG : ST_DONE;
      ST_LOG:    state_nxt = ST_PRUNE;
      ST_PRUNE:  if (!expired) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_LOG:   ctl.push  = 1'b1;
      ST_PRUNE: ctl.pop   = expired;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_thr_r  <= STALE_RST;
      miss_limit_r <= LIMIT_RST;
      storm_cnt_r  <= STORM_RST;
      storm_win_r  <= WINDOW_RST;
    end else if (cfg_wr_en) begin
      unique case (hbw_reg_t'(cfg_index))
        REG_STALE_THR:  stale_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_MISS_LIMIT: miss_limit_r <= cfg_wdata[MISS_W-1:0];
        REG_STORM_CNT:  storm_cnt_r  <= cfg_wdata[STORM_W-1:0];
        REG_STORM_WIN:  storm_win_r  <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      now_r   <= in_tdata[TIME_BITS-1:0];
      hb_r    <= in_tdata[2*TIME_BITS-1:TIME_BITS];
      alive_r <= in_tdata[2*TIME_BITS];
      pend_r  <= in_tdata[2*TIME_BITS+1];
    end
    if (state_r == ST_CALC) begin
      skip_r <= skip;
    end
    if (state_r == ST_DONE && out_free) begin
      out_tdata_r <= {skip_r, STORM_W'(count), miss_r, fatal_r, request_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      miss_r       <= '0;
      fatal_r      <= 1'b0;
      request_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC) begin
        request_r <= 1'b0;
        if (!skip) begin
          miss_r <= miss_nxt;
        end
      end
      if (state_r == ST_DECIDE) begin
        if (storm) begin
          fatal_r <= 1'b1;
        end else begin
          miss_r    <= '0;
          request_r <= 1'b1;
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

// File: sim/tb_heartbeat_watchdog_storm_limit.sv
`timescale 1ns / 1ps

module tb_heartbeat_watchdog_storm_limit;
  import hbw_pkg::*;

  localparam int TB_TIME_W   = TIME_BITS_DEF;
  localparam int TICK_W      = ((2 * TB_TIME_W + 2 + 7) / 8) * 8;
  localparam int LOG_DEPTH   = MAX_RESETS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYC  = 40;

  typedef logic [TB_TIME_W-1:0] ms_t;

  typedef struct packed {
    ms_t  now_ms;
    ms_t  hb_ms;
    logic alive;
    logic pending;
  } tick_t;

  typedef struct packed {
    logic               request;
    logic               fatal;
    logic [MISS_W-1:0]  misses;
    logic [STORM_W-1:0] recent;
    logic               skipped;
  } verdict_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE
  } sink_mode_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // now_ms, heartbeat_ms, worker_alive, reset_pending, zero fill
  logic [TICK_W-1:0]    in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // request_reset, fatal_stop, misses[7:0], recent_resets[4:0], skipped
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STALE_THR;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  heartbeat_watchdog_storm_limit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the configuration registers.
  logic [THR_W-1:0]   thr_q    = STALE_RST;
  logic [MISS_W-1:0]  limit_q  = LIMIT_RST;
  logic [STORM_W-1:0] storm_q  = STORM_RST;
  logic [WIN_W-1:0]   window_q = WINDOW_RST;

  // Watchdog state as the predictor sees it.
  logic [MISS_W-1:0]  wd_misses = '0;
  logic               wd_fatal  = 1'b0;
  ms_t                reset_log [LOG_DEPTH];
  logic [3:0]         log_head  = '0;
  logic [4:0]         log_count = '0;

  tick_t    tick_q[$];
  verdict_t verdict_q[$];
  tick_t    cur_tick;
  verdict_t want;
  ms_t      clock_ms;

  int fail_count = 0;
  int ticks_checked = 0;
  int resets_seen = 0;
  int skipped_seen = 0;
  int fatal_seen = 0;

  // One watchdog tick: updates the predicted state and returns the result.
  function automatic verdict_t judge_tick(input tick_t t);
    verdict_t   v;
    logic       skip;
    logic       stale;
    logic       req;
    logic [3:0] slot;
    skip = !t.alive || wd_fatal || t.pending;
    req  = 1'b0;
    if (!skip) begin
      stale = (t.hb_ms <= t.now_ms) && ((t.now_ms - t.hb_ms) > ms_t'(thr_q));
      if (stale) begin
        if (wd_misses != '1) wd_misses = wd_misses + 1'b1;
      end else begin
        wd_misses = '0;
      end
      if (wd_misses >= limit_q) begin
        // A full log drops its oldest time before taking the new one.
        if (log_count == 5'(LOG_DEPTH)) begin
          log_head  = log_head + 1'b1;
          log_count = 5'(LOG_DEPTH - 1);
        end
        slot = log_head + log_count[3:0];
        reset_log[slot] = t.now_ms;
        log_count = log_count + 1'b1;
        // Pruning stops at the first time that lies in the window or in the future.
        while (log_count != 0 && reset_log[log_head] <= t.now_ms &&
               (t.now_ms - reset_log[log_head]) > ms_t'(window_q)) begin
          log_head  = log_head + 1'b1;
          log_count = log_count - 1'b1;
        end
        if (log_count >= 5'(storm_q)) begin
          wd_fatal = 1'b1;
        end else begin
          wd_misses = '0;
          req = 1'b1;
        end
      end
    end
    v.request = req;
    v.fatal   = wd_fatal;
    v.misses  = wd_misses;
    v.recent  = log_count;
    v.skipped = skip;
    return v;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) verdict_q.insert(verdict_q.size(), judge_tick(cur_tick));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q[0];
          tick_q.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= {{(TICK_W - 2 * TB_TIME_W - 2){1'b0}}, cur_tick.pending,
                        cur_tick.alive, cur_tick.hb_ms, cur_tick.now_ms};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern whose mode (always ready, random, sparse) changes at random.
  sink_mode_t sink_mode = READY_ALWAYS;
  int sink_left = 0;
  int sink_cyc = 0;

  always @(posedge clk) begin
    sink_cyc <= sink_cyc + 1;
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 2));
      sink_left <= $urandom_range(20, 150);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      default:      out_tready <= (sink_cyc % 6 == 0);
    endcase
  end

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result transaction with no tick outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        compare_field("request_reset", 8'(want.request), 8'(out_tdata[0]));
        compare_field("fatal_stop", 8'(want.fatal), 8'(out_tdata[1]));
        compare_field("misses", want.misses, out_tdata[9:2]);
        compare_field("recent_resets", 8'(want.recent), 8'(out_tdata[14:10]));
        compare_field("skipped", 8'(want.skipped), 8'(out_tdata[15]));
        ticks_checked++;
        if (want.request) resets_seen++;
        if (want.skipped) skipped_seen++;
        if (want.fatal) fatal_seen++;
      end
    end
  end

  int quiet_cyc = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= QUIET_LIMIT) begin
        $display("No transaction for %0d cycles, %0d results outstanding",
                 quiet_cyc, verdict_q.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  task automatic push_tick(input ms_t now_v, input ms_t hb_v, input logic alive_v,
                           input logic pending_v);
    tick_t t;
    t.now_ms  = now_v;
    t.hb_ms   = hb_v;
    t.alive   = alive_v;
    t.pending = pending_v;
    tick_q.insert(tick_q.size(), t);
  endtask

  task automatic set_reg(input hbw_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_STALE_THR:  thr_q    = val[THR_W-1:0];
      REG_MISS_LIMIT: limit_q  = val[MISS_W-1:0];
      REG_STORM_CNT:  storm_q  = val[STORM_W-1:0];
      default:        window_q = val[WIN_W-1:0];
    endcase
  endtask

  task automatic configure(input int thr, input int limit, input int storm, input int window);
    set_reg(REG_STALE_THR, CFG_W'(thr));
    set_reg(REG_MISS_LIMIT, CFG_W'(limit));
    set_reg(REG_STORM_CNT, CFG_W'(storm));
    set_reg(REG_STORM_WIN, CFG_W'(window));
  endtask

  // Returns once every tick was sent and every result has come back.
  task automatic drain();
    @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
  endtask

  // Mostly ticks on a running clock with aged heartbeats; the rest is noise.
  task automatic add_random_ticks(input int count, input int stale_pct, input int noise_pct,
                                  input int step_max);
    tick_t t;
    ms_t   age;
    int    r;
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct) begin
        t.now_ms  = {8'($urandom), 32'($urandom)};
        t.hb_ms   = ($urandom_range(0, 3) == 0) ? '0 : {8'($urandom), 32'($urandom)};
        t.alive   = 1'($urandom_range(0, 1));
        t.pending = 1'($urandom_range(0, 1));
      end else begin
        clock_ms = clock_ms + ms_t'($urandom_range(1, step_max));
        t.now_ms = clock_ms;
        if ($urandom_range(0, 99) < stale_pct) begin
          age = ms_t'(thr_q) + 1 + (($urandom_range(0, 3) == 0) ?
                ms_t'($urandom_range(0, 100000)) : ms_t'($urandom_range(0, 3)));
          t.hb_ms = clock_ms - age;
        end else begin
          case ($urandom_range(0, 5))
            4:       t.hb_ms = clock_ms + ms_t'($urandom_range(1, 1000));
            5:       t.hb_ms = '0;
            default: t.hb_ms = clock_ms - ms_t'($urandom_range(0, thr_q));
          endcase
        end
        t.alive   = ($urandom_range(0, 49) != 0);
        t.pending = ($urandom_range(0, 49) == 0);
      end
      tick_q.insert(tick_q.size(), t);
    end
  endtask

  localparam ms_t T0 = 50000;

  initial begin
    int window;
    clock_ms = {8'h10, 32'($urandom)};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: skip reasons, age boundaries, extremes of time, one reset request.
    @(negedge clk);
    push_tick(T0, T0 - 100, 1'b0, 1'b0);
    push_tick(T0, T0 - 100, 1'b1, 1'b1);
    push_tick(T0, T0 - 100, 1'b0, 1'b1);
    push_tick('0, '0, 1'b1, 1'b0);
    push_tick('1, '1, 1'b1, 1'b0);
    push_tick(T0, T0 - 2000, 1'b1, 1'b0);
    push_tick(T0, T0 + 5, 1'b1, 1'b0);
    push_tick(T0 + 1000, T0 + 1000 - 2001, 1'b1, 1'b0);
    for (int k = 2; k <= 10; k++) push_tick(T0 + ms_t'(1000 * k), '0, 1'b1, 1'b0);
    drain();

    // Miss limit zero: every tick that is not skipped logs a reset. A logged time
    // far in the future blocks pruning, and the log overflows.
    configure(1, 0, 31, 3600000);
    @(negedge clk);
    push_tick(40'hF0_0000_0000, '0, 1'b1, 1'b0);
    push_tick(clock_ms, clock_ms + 7, 1'b1, 1'b0);
    push_tick(clock_ms, '0, 1'b0, 1'b0);
    push_tick(clock_ms, clock_ms, 1'b1, 1'b0);
    add_random_ticks(60, 50, 10, 1000);
    drain();

    // Large threshold, largest miss limit, window of 1.
    configure(3600000, 255, 17, 1);
    add_random_ticks(300, 100, 0, 5);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       window = 1;
        1:       window = $urandom_range(100, 20000);
        2:       window = 3600000;
        default: window = $urandom_range(1000, 50000);
      endcase
      configure($urandom_range(1, 5000), $urandom_range(1, 5), $urandom_range(17, 31), window);
      add_random_ticks(90, 70, 8, (window / 8 > 100000) ? 100000 : window / 8 + 1);
      drain();
    end

    // Storm count zero: the first reset decision is fatal, later ticks are skipped.
    configure(2000, 1, 0, 180000);
    @(negedge clk);
    clock_ms = clock_ms + 10;
    push_tick(clock_ms, '0, 1'b1, 1'b0);
    push_tick(clock_ms + 1, clock_ms + 1, 1'b1, 1'b0);
    push_tick(clock_ms + 2, '0, 1'b1, 1'b0);
    drain();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Checked %0d ticks over 8 register settings: %0d reset requests, %0d skipped,",
             ticks_checked, resets_seen, skipped_seen);
    $display("%0d results with the worker fatal, %0d mismatches", fatal_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hbw_pkg.sv
hw/rtl/hbw_cell.sv
hw/rtl/hbw_chain.sv
hw/rtl/heartbeat_watchdog_storm_limit.sv
sim/tb_heartbeat_watchdog_storm_limit.sv
